// ----- design/bra_pkg.sv -----
// ----------------------------------------------------------------------------
// bra_pkg
// shared widths, constants and state codes of the rational approximation core
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned FRAC_BITS      = 32;
  localparam int unsigned INT_LIMIT_BITS = 31;
  localparam int unsigned VAL_W          = 63;
  localparam int unsigned DEN_W          = 31;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned ACC_W          = 128;
  localparam int unsigned CHUNK_W        = 32;
  localparam int unsigned K_W            = 2;
  localparam int unsigned CNT_W          = $clog2(WORD_W);

  localparam logic [DEN_W-1:0] MAX_DEN_RST = DEN_W'(65535);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_POST = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef enum logic [10:0] {
    STEP_TERM = 11'b00000000001,
    STEP_DEN  = 11'b00000000010,
    STEP_NUM  = 11'b00000000100,
    STEP_FIN  = 11'b00000001000,
    STEP_SEMI = 11'b00000010000,
    STEP_SNUM = 11'b00000100000,
    STEP_SDEN = 11'b00001000000,
    STEP_W1   = 11'b00010000000,
    STEP_E1   = 11'b00100000000,
    STEP_W2   = 11'b01000000000,
    STEP_E2   = 11'b10000000000
  } step_e;

endpackage

// ----- design/bra_div.sv -----
// ----------------------------------------------------------------------------
// bra_div
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bra_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bra_pkg::WORD_W-1:0] dividend_i,
  input  logic [bra_pkg::WORD_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [bra_pkg::WORD_W-1:0] quo_o,
  output logic [bra_pkg::WORD_W-1:0] rem_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [bra_pkg::CNT_W-1:0]  cnt_q;
  logic [bra_pkg::WORD_W-1:0] dq_q;
  logic [bra_pkg::WORD_W-1:0] rem_q;
  logic [bra_pkg::WORD_W-1:0] dvs_q;
  logic [bra_pkg::WORD_W:0]   rs;
  logic [bra_pkg::WORD_W:0]   diff;
  logic                       ge;

  assign rs   = {rem_q, dq_q[bra_pkg::WORD_W-1]};
  assign diff = rs - {1'b0, dvs_q};
  assign ge   = rs >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == {bra_pkg::CNT_W{1'b1}}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[bra_pkg::WORD_W-1:0] : rs[bra_pkg::WORD_W-1:0];
      dq_q  <= {dq_q[bra_pkg::WORD_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = dq_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/bra_mul.sv -----
// ----------------------------------------------------------------------------
// bra_mul
// 32 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
module bra_mul (
  input  logic                          clk_i,
  input  logic [bra_pkg::CHUNK_W-1:0]   a_i,
  input  logic [bra_pkg::CHUNK_W-1:0]   b_i,
  output logic [2*bra_pkg::CHUNK_W-1:0] prod_o
);

  logic [2*bra_pkg::CHUNK_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- design/best_rational_approximation_core.sv -----
// ----------------------------------------------------------------------------
// best_rational_approximation_core
// best rational approximation of an unsigned q31.32 value under a denominator limit
// ----------------------------------------------------------------------------
// Each word on the input takes one value and yields one numerator/denominator
// pair. The value is expanded as a continued fraction by a Euclid chain on a
// shared 64-bit shift-subtract divider (the first term is a plain shift of
// the value) and a shared 32x32 multiplier for the convergent updates. Each
// term takes up to one division and two multiplies; the semiconvergent and
// the exact error comparison add one more division and further multiplies.
// in_stall_o is high while an item is at work. A finished pair waits in the
// output register, so the next value can be taken while it is still stalled.
// max_denominator is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the block is idle, the block does not enforce this; zero acts
// as one.
// ----------------------------------------------------------------------------
module best_rational_approximation_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bra_pkg::DEN_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bra_pkg::VAL_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bra_pkg::VAL_W-1:0]  numerator_o,
  output logic [bra_pkg::DEN_W-1:0]  denominator_o
);

  localparam int unsigned WW = bra_pkg::WORD_W;
  localparam int unsigned AW = bra_pkg::ACC_W;
  localparam int unsigned DW = bra_pkg::DEN_W;
  localparam int unsigned CW = bra_pkg::CHUNK_W;
  localparam int unsigned KW = bra_pkg::K_W;

  // control
  bra_pkg::state_e state_q, state_d;
  bra_pkg::step_e  step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   max_den_q;

  // euclid chain and convergents
  logic [WW-1:0] p_q, p_d, q_q, q_d, rem_q, rem_d;
  logic [WW-1:0] nc_q, nc_d, np_q, np_d, ns_q, ns_d;
  logic [DW-1:0] dc_q, dc_d, dp_q, dp_d, ds_q, ds_d, tden_q, tden_d, lim_q, lim_d;
  logic [CW-1:0] a_q, a_d, semi_q, semi_d;
  logic [bra_pkg::VAL_W-1:0] v_q, v_d;
  logic [AW-1:0] err1_q, err1_d;

  // long multiply sequencing
  logic [AW-1:0] acc_q, acc_d, mop_a_q, mop_a_d;
  logic [CW-1:0] mop_b_q, mop_b_d;
  logic [KW-1:0] k_q, k_d, last_q, last_d;

  logic [bra_pkg::VAL_W-1:0] num_q, num_d;
  logic [DW-1:0]             den_q, den_d;

  // shared units
  logic          div_go, div_busy, div_done;
  logic [WW-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic          mul_go;
  logic [AW-1:0] mul_acc0, mul_a;
  logic [CW-1:0] mul_b;
  logic [KW-1:0] mul_last;
  logic [2*CW-1:0] prod;
  logic [AW-1:0]   prod_sh;
  logic [CW-1:0]   chunk;

  logic            accept;
  logic [AW-1:0]   e_w;
  logic [AW-1:0]   lq;

  function automatic logic [AW-1:0] absdiff(input logic [AW-1:0] x, input logic [AW-1:0] y);
    absdiff = (x < y) ? (y - x) : (x - y);
  endfunction

  bra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign chunk = mop_a_q[{k_q, 5'b0} +: CW];

  bra_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (chunk),
    .b_i    (mop_b_q),
    .prod_o (prod)
  );

  // partial product lands at chunk position k
  assign prod_sh = AW'(prod) << {k_q, 5'b0};

  assign accept     = in_valid_i && (state_q == bra_pkg::ST_IDLE);
  assign in_stall_o = (state_q != bra_pkg::ST_IDLE);

  // p > L*q  with L = 2^INT_LIMIT_BITS - 1, taken on the swapped pair
  assign lq = (AW'(rem_q) << bra_pkg::INT_LIMIT_BITS) - AW'(rem_q);

  always_comb begin
    state_d = state_q;  step_d = step_q;  out_valid_d = out_valid_q;
    p_d = p_q;  q_d = q_q;  rem_d = rem_q;
    nc_d = nc_q;  np_d = np_q;  ns_d = ns_q;
    dc_d = dc_q;  dp_d = dp_q;  ds_d = ds_q;  tden_d = tden_q;  lim_d = lim_q;
    a_d = a_q;  semi_d = semi_q;  v_d = v_q;  err1_d = err1_q;
    acc_d = acc_q;  mop_a_d = mop_a_q;  mop_b_d = mop_b_q;
    k_d = k_q;  last_d = last_q;
    num_d = num_q;  den_d = den_q;
    div_go = 1'b0;  div_dvd = p_q;  div_dvs = q_q;
    mul_go = 1'b0;  mul_acc0 = '0;  mul_a = '0;  mul_b = '0;  mul_last = '0;
    e_w = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bra_pkg::ST_IDLE: begin
        if (accept) begin
          v_d   = value_i;
          lim_d = (max_den_q == '0) ? DW'(1) : max_den_q;
          p_d   = WW'(value_i);
          q_d   = WW'(1) << bra_pkg::FRAC_BITS;
          nc_d  = WW'(1);
          np_d  = '0;
          dc_d  = '0;
          dp_d  = DW'(1);
          // first term is the integer part, the remainder the fraction bits
          a_d   = CW'(value_i[bra_pkg::VAL_W-1:bra_pkg::FRAC_BITS]);
          rem_d = WW'(value_i[bra_pkg::FRAC_BITS-1:0]);
          // next denominator 0*a + 1
          mul_go = 1'b1;  mul_acc0 = AW'(1);  mul_a = '0;
          mul_b = CW'(value_i[bra_pkg::VAL_W-1:bra_pkg::FRAC_BITS]);  mul_last = KW'(0);
          step_d = bra_pkg::STEP_DEN;
        end
      end
      bra_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = bra_pkg::ST_POST;
        end
      end
      bra_pkg::ST_MUL: begin
        state_d = bra_pkg::ST_ACC;
      end
      bra_pkg::ST_ACC: begin
        acc_d = acc_q + prod_sh;
        if (k_q == last_q) begin
          state_d = bra_pkg::ST_POST;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = bra_pkg::ST_MUL;
        end
      end
      bra_pkg::ST_POST: begin
        case (step_q)
          bra_pkg::STEP_TERM: begin
            a_d   = div_quo[CW-1:0];
            rem_d = div_rem;
            // next denominator dc*a + dp
            mul_go = 1'b1;  mul_acc0 = AW'(dp_q);  mul_a = AW'(dc_q);
            mul_b = div_quo[CW-1:0];  mul_last = KW'(0);
            step_d = bra_pkg::STEP_DEN;
          end
          bra_pkg::STEP_DEN: begin
            if (acc_q > AW'(lim_q)) begin
              step_d = bra_pkg::STEP_FIN;
            end else begin
              tden_d = acc_q[DW-1:0];
              mul_go = 1'b1;  mul_acc0 = AW'(np_q);  mul_a = AW'(nc_q);
              mul_b = a_q;  mul_last = KW'(1);
              step_d = bra_pkg::STEP_NUM;
            end
          end
          bra_pkg::STEP_NUM: begin
            np_d = nc_q;
            nc_d = acc_q[WW-1:0];
            dp_d = dc_q;
            dc_d = tden_q;
            if (rem_q == '0) begin
              step_d = bra_pkg::STEP_FIN;
            end else begin
              p_d = q_q;
              q_d = rem_q;
              // reciprocal cap: stop when the next term would exceed the limit
              if (AW'(q_q) > lq) begin
                step_d = bra_pkg::STEP_FIN;
              end else begin
                div_go  = 1'b1;
                div_dvd = q_q;
                div_dvs = rem_q;
                step_d  = bra_pkg::STEP_TERM;
              end
            end
          end
          bra_pkg::STEP_FIN: begin
            // largest semiconvergent term (lim - dp) / dc
            div_go  = 1'b1;
            div_dvd = WW'(lim_q - dp_q);
            div_dvs = WW'(dc_q);
            step_d  = bra_pkg::STEP_SEMI;
          end
          bra_pkg::STEP_SEMI: begin
            semi_d = div_quo[CW-1:0];
            mul_go = 1'b1;  mul_acc0 = AW'(np_q);  mul_a = AW'(nc_q);
            mul_b = div_quo[CW-1:0];  mul_last = KW'(1);
            step_d = bra_pkg::STEP_SNUM;
          end
          bra_pkg::STEP_SNUM: begin
            ns_d = acc_q[WW-1:0];
            mul_go = 1'b1;  mul_acc0 = AW'(dp_q);  mul_a = AW'(dc_q);
            mul_b = semi_q;  mul_last = KW'(0);
            step_d = bra_pkg::STEP_SDEN;
          end
          bra_pkg::STEP_SDEN: begin
            ds_d = acc_q[DW-1:0];
            mul_go = 1'b1;  mul_acc0 = '0;  mul_a = AW'(v_q);
            mul_b = CW'(dc_q);  mul_last = KW'(1);
            step_d = bra_pkg::STEP_W1;
          end
          bra_pkg::STEP_W1: begin
            e_w = absdiff(acc_q, AW'(nc_q) << bra_pkg::FRAC_BITS);
            mul_go = 1'b1;  mul_acc0 = '0;  mul_a = e_w;
            mul_b = CW'(ds_q);  mul_last = KW'(3);
            step_d = bra_pkg::STEP_E1;
          end
          bra_pkg::STEP_E1: begin
            err1_d = acc_q;
            mul_go = 1'b1;  mul_acc0 = '0;  mul_a = AW'(v_q);
            mul_b = CW'(ds_q);  mul_last = KW'(1);
            step_d = bra_pkg::STEP_W2;
          end
          bra_pkg::STEP_W2: begin
            e_w = absdiff(acc_q, AW'(ns_q) << bra_pkg::FRAC_BITS);
            mul_go = 1'b1;  mul_acc0 = '0;  mul_a = e_w;
            mul_b = CW'(dc_q);  mul_last = KW'(3);
            step_d = bra_pkg::STEP_E2;
          end
          bra_pkg::STEP_E2: begin
            // both errors held, pick when the output register is free
            state_d = bra_pkg::ST_DONE;
          end
          default: begin
            state_d = bra_pkg::ST_IDLE;
          end
        endcase
      end
      bra_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          // strict compare: a tie goes to the semiconvergent
          if (err1_q < acc_q) begin
            num_d = nc_q[bra_pkg::VAL_W-1:0];
            den_d = dc_q;
          end else begin
            num_d = ns_q[bra_pkg::VAL_W-1:0];
            den_d = ds_q;
          end
          out_valid_d = 1'b1;
          state_d     = bra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase

    if (div_go) begin
      state_d = bra_pkg::ST_DIV;
    end
    if (mul_go) begin
      acc_d   = mul_acc0;
      mop_a_d = mul_a;
      mop_b_d = mul_b;
      last_d  = mul_last;
      k_d     = '0;
      state_d = bra_pkg::ST_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bra_pkg::ST_IDLE;
      step_q      <= bra_pkg::STEP_TERM;
      out_valid_q <= 1'b0;
      max_den_q   <= bra_pkg::MAX_DEN_RST;
      k_q         <= '0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      last_q      <= last_d;
      if (cfg_we_i) begin
        max_den_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;  q_q <= q_d;  rem_q <= rem_d;
    nc_q <= nc_d;  np_q <= np_d;  ns_q <= ns_d;
    dc_q <= dc_d;  dp_q <= dp_d;  ds_q <= ds_d;  tden_q <= tden_d;  lim_q <= lim_d;
    a_q <= a_d;  semi_q <= semi_d;  v_q <= v_d;  err1_q <= err1_d;
    acc_q <= acc_d;  mop_a_q <= mop_a_d;  mop_b_q <= mop_b_d;
    num_q <= num_d;  den_q <= den_d;
  end

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = num_q;
  assign denominator_o = den_q;

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> denominator_o != '0)
    else $error("zero denominator delivered");

  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bra_pkg::ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bra_pkg::ST_MUL) |-> (k_q <= last_q))
    else $error("multiply chunk index past last");
`endif

endmodule
